FILE: hw/rtl/svf_pkg.sv
`timescale 1ns / 1ps
// shared types, field widths and codes of the smoothed viewport follow block
// no dependencies

package svf_pkg;

	localparam int POS_W         = 32;
	localparam int PIX_W         = 24;
	localparam int SIZE_W        = 16;
	localparam int GAIN_W        = 17;
	localparam int GAIN_FRAC     = 16;
	localparam int MODE_W        = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 17;
	localparam int FRAC_BITS_DEF = 8;
	localparam int ROOT_STEPS    = POS_W + 1;
	localparam int CNT_W         = 6;

	localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << GAIN_FRAC;
	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);
	localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(6554);

	localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_JUMP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GOTO = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_GAIN = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SUM,
		ST_CHK,
		ST_ROOT,
		ST_VMUL,
		ST_VCMP,
		ST_MULY,
		ST_TAKEY,
		ST_DIV,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_SQX,
		OP_SQY,
		OP_SUM,
		OP_CHECK,
		OP_ROOT,
		OP_VMUL,
		OP_MULX,
		OP_MULY,
		OP_TAKEY,
		OP_DIV,
		OP_APPLY,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic div_first;
	} cmd_t;

	typedef struct packed {
		logic snap;
		logic big;
	} status_t;

endpackage

FILE: hw/rtl/svf_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the smoothed viewport follow block: handshakes and step order
// depends on svf_pkg

module svf_ctrl #(
	parameter int FRAC_BITS = svf_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [svf_pkg::MODE_W-1:0]   mode,
	output logic                         in_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	input  svf_pkg::status_t             status,
	output svf_pkg::cmd_t                cmd
);

	svf_pkg::state_t             state_q;
	svf_pkg::state_t             state_nxt;
	logic [svf_pkg::CNT_W-1:0]   cnt_q;
	logic                        out_valid_q;
	logic                        out_free;
	logic                        root_last;
	logic                        div_last;

	assign out_free  = !out_valid_q || out_ready;
	assign root_last = cnt_q == svf_pkg::CNT_W'(svf_pkg::ROOT_STEPS - 1);
	assign div_last  = cnt_q == svf_pkg::CNT_W'(FRAC_BITS);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			svf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (mode == svf_pkg::MODE_TICK) ? svf_pkg::ST_SQX
						: svf_pkg::ST_DONE;
				end
			end
			svf_pkg::ST_SQX:   state_nxt = svf_pkg::ST_SQY;
			svf_pkg::ST_SQY:   state_nxt = svf_pkg::ST_SUM;
			svf_pkg::ST_SUM:   state_nxt = svf_pkg::ST_CHK;
			svf_pkg::ST_CHK:   state_nxt = status.snap ? svf_pkg::ST_DONE : svf_pkg::ST_ROOT;
			svf_pkg::ST_ROOT:  state_nxt = root_last ? svf_pkg::ST_VMUL : svf_pkg::ST_ROOT;
			svf_pkg::ST_VMUL:  state_nxt = svf_pkg::ST_VCMP;
			svf_pkg::ST_VCMP:  state_nxt = status.big ? svf_pkg::ST_MULY : svf_pkg::ST_DIV;
			svf_pkg::ST_MULY:  state_nxt = svf_pkg::ST_TAKEY;
			svf_pkg::ST_TAKEY: state_nxt = svf_pkg::ST_APPLY;
			svf_pkg::ST_DIV:   state_nxt = div_last ? svf_pkg::ST_APPLY : svf_pkg::ST_DIV;
			svf_pkg::ST_APPLY: state_nxt = svf_pkg::ST_DONE;
			svf_pkg::ST_DONE:  state_nxt = out_free ? svf_pkg::ST_IDLE : svf_pkg::ST_DONE;
			default:           state_nxt = svf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.op        = svf_pkg::OP_NONE;
		cmd.div_first = (cnt_q == '0);
		unique case (state_q)
			svf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = svf_pkg::OP_ACCEPT;
				end
			end
			svf_pkg::ST_SQX:   cmd.op = svf_pkg::OP_SQX;
			svf_pkg::ST_SQY:   cmd.op = svf_pkg::OP_SQY;
			svf_pkg::ST_SUM:   cmd.op = svf_pkg::OP_SUM;
			svf_pkg::ST_CHK:   cmd.op = svf_pkg::OP_CHECK;
			svf_pkg::ST_ROOT:  cmd.op = svf_pkg::OP_ROOT;
			svf_pkg::ST_VMUL:  cmd.op = svf_pkg::OP_VMUL;
			svf_pkg::ST_VCMP:  cmd.op = svf_pkg::OP_MULX;
			svf_pkg::ST_MULY:  cmd.op = svf_pkg::OP_MULY;
			svf_pkg::ST_TAKEY: cmd.op = svf_pkg::OP_TAKEY;
			svf_pkg::ST_DIV:   cmd.op = svf_pkg::OP_DIV;
			svf_pkg::ST_APPLY: cmd.op = svf_pkg::OP_APPLY;
			svf_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.op = svf_pkg::OP_OUT;
				end
			end
			default:           cmd.op = svf_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svf_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == svf_pkg::ST_ROOT && !root_last)
					|| (state_q == svf_pkg::ST_DIV && !div_last)) begin
				cnt_q <= cnt_q + svf_pkg::CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.op == svf_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/svf_datapath.sv
`timescale 1ns / 1ps
// datapath: config registers, position and target, shared multiplier,
// bit-serial square root and dual divider, result register; depends on svf_pkg

module svf_datapath #(
	parameter int FRAC_BITS = svf_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [svf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [svf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [svf_pkg::MODE_W-1:0]          mode,
	input  logic                                centered,
	input  logic signed [svf_pkg::PIX_W-1:0]    coord_x,
	input  logic signed [svf_pkg::PIX_W-1:0]    coord_y,
	input  svf_pkg::cmd_t                       cmd,
	output svf_pkg::status_t                    status,
	output logic signed [svf_pkg::POS_W-1:0]    pos_x,
	output logic signed [svf_pkg::POS_W-1:0]    pos_y,
	output logic                                at_target
);

	localparam int POS_W  = svf_pkg::POS_W;
	localparam int PIX_W  = svf_pkg::PIX_W;
	localparam int SIZE_W = svf_pkg::SIZE_W;
	localparam int DIFF_W = POS_W + 1;
	localparam int MAG_W  = POS_W;
	localparam int SUM_W  = 2 * MAG_W + 1;
	localparam int ROOT_W = svf_pkg::ROOT_STEPS;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int MUL_W  = ROOT_W;
	localparam int PROD_W = 2 * MUL_W;
	localparam int EXT_W  = POS_W - PIX_W - 1;

	logic [SIZE_W-1:0]          view_w_q;
	logic [SIZE_W-1:0]          view_h_q;
	logic [svf_pkg::GAIN_W-1:0] gain_q;

	logic [POS_W-1:0]  pos_x_q;
	logic [POS_W-1:0]  pos_y_q;
	logic [POS_W-1:0]  tgt_x_q;
	logic [POS_W-1:0]  tgt_y_q;
	logic [DIFF_W-1:0] dx_q;
	logic [DIFF_W-1:0] dy_q;
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0]  sum_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] drx_q;
	logic [ROOT_W-1:0] dry_q;
	logic [MAG_W-1:0]  qx_q;
	logic [MAG_W-1:0]  qy_q;
	logic [POS_W-1:0]  out_x_q;
	logic [POS_W-1:0]  out_y_q;
	logic              out_at_q;

	logic [SIZE_W-1:0]          half_w;
	logic [SIZE_W-1:0]          half_h;
	logic [PIX_W:0]             cx_pix;
	logic [PIX_W:0]             cy_pix;
	logic [POS_W-1:0]           cx_ext;
	logic [POS_W-1:0]           cy_ext;
	logic [POS_W-1:0]           cx_fix;
	logic [POS_W-1:0]           cy_fix;
	logic [DIFF_W-1:0]          negx;
	logic [DIFF_W-1:0]          negy;
	logic [MAG_W-1:0]           mx;
	logic [MAG_W-1:0]           my;
	logic [svf_pkg::GAIN_W-1:0] gain_sat;
	logic [MUL_W-1:0]           mul_a;
	logic [MUL_W-1:0]           mul_b;
	logic [PROD_W-1:0]          mul_p;
	logic [REM_W+1:0]           rem_sh;
	logic [REM_W+1:0]           trial;
	logic                       root_fit;
	logic [ROOT_W:0]            drx_sh;
	logic [ROOT_W:0]            dry_sh;
	logic                       dgx;
	logic                       dgy;

	// command coordinates: (pixel - half size) scaled to fixed point, wrapped
	assign half_w = centered ? {1'b0, view_w_q[SIZE_W-1:1]} : '0;
	assign half_h = centered ? {1'b0, view_h_q[SIZE_W-1:1]} : '0;
	assign cx_pix = {coord_x[PIX_W-1], coord_x} - {{(PIX_W + 1 - SIZE_W){1'b0}}, half_w};
	assign cy_pix = {coord_y[PIX_W-1], coord_y} - {{(PIX_W + 1 - SIZE_W){1'b0}}, half_h};
	assign cx_ext = {{EXT_W{cx_pix[PIX_W]}}, cx_pix};
	assign cy_ext = {{EXT_W{cy_pix[PIX_W]}}, cy_pix};
	assign cx_fix = cx_ext << FRAC_BITS;
	assign cy_fix = cy_ext << FRAC_BITS;

	assign negx = -dx_q;
	assign negy = -dy_q;
	assign mx   = dx_q[DIFF_W-1] ? negx[MAG_W-1:0] : dx_q[MAG_W-1:0];
	assign my   = dy_q[DIFF_W-1] ? negy[MAG_W-1:0] : dy_q[MAG_W-1:0];

	assign gain_sat = (gain_q > svf_pkg::GAIN_ONE) ? svf_pkg::GAIN_ONE : gain_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			svf_pkg::OP_SQX: begin
				mul_a = MUL_W'(mx);
				mul_b = MUL_W'(mx);
			end
			svf_pkg::OP_SQY: begin
				mul_a = MUL_W'(my);
				mul_b = MUL_W'(my);
			end
			svf_pkg::OP_VMUL: begin
				mul_a = root_q;
				mul_b = MUL_W'(gain_sat);
			end
			svf_pkg::OP_MULX: begin
				mul_a = MUL_W'(mx);
				mul_b = MUL_W'(gain_sat);
			end
			svf_pkg::OP_MULY: begin
				mul_a = MUL_W'(my);
				mul_b = MUL_W'(gain_sat);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign status.snap = sum_q <= (SUM_W'(1) << (2 * FRAC_BITS));
	assign status.big  = prod_q >= (PROD_W'(1) << (svf_pkg::GAIN_FRAC + FRAC_BITS));

	// one root bit per step
	assign rem_sh   = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign root_fit = rem_sh >= trial;

	// one quotient bit per step on each axis, divisor is the distance rounded down
	assign drx_sh = {drx_q, cmd.div_first ? mx[0] : 1'b0};
	assign dry_sh = {dry_q, cmd.div_first ? my[0] : 1'b0};
	assign dgx    = drx_sh >= {1'b0, root_q};
	assign dgy    = dry_sh >= {1'b0, root_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_w_q <= svf_pkg::WIDTH_RST;
			view_h_q <= svf_pkg::HEIGHT_RST;
			gain_q   <= svf_pkg::GAIN_RST;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			tgt_x_q  <= '0;
			tgt_y_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					svf_pkg::CFG_VIEW_WIDTH:  view_w_q <= cfg_data[SIZE_W-1:0];
					svf_pkg::CFG_VIEW_HEIGHT: view_h_q <= cfg_data[SIZE_W-1:0];
					svf_pkg::CFG_FOLLOW_GAIN: gain_q   <= cfg_data[svf_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
			case (cmd.op)
				svf_pkg::OP_ACCEPT: begin
					if (mode == svf_pkg::MODE_JUMP || mode == svf_pkg::MODE_GOTO) begin
						tgt_x_q <= cx_fix;
						tgt_y_q <= cy_fix;
					end
					if (mode == svf_pkg::MODE_JUMP) begin
						pos_x_q <= cx_fix;
						pos_y_q <= cy_fix;
					end
				end
				svf_pkg::OP_CHECK: begin
					if (status.snap) begin
						pos_x_q <= tgt_x_q;
						pos_y_q <= tgt_y_q;
					end
				end
				svf_pkg::OP_APPLY: begin
					pos_x_q <= dx_q[DIFF_W-1] ? pos_x_q - qx_q : pos_x_q + qx_q;
					pos_y_q <= dy_q[DIFF_W-1] ? pos_y_q - qy_q : pos_y_q + qy_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			svf_pkg::OP_ACCEPT: begin
				dx_q <= {tgt_x_q[POS_W-1], tgt_x_q} - {pos_x_q[POS_W-1], pos_x_q};
				dy_q <= {tgt_y_q[POS_W-1], tgt_y_q} - {pos_y_q[POS_W-1], pos_y_q};
			end
			svf_pkg::OP_SQX: begin
				prod_q <= mul_p;
			end
			svf_pkg::OP_SQY: begin
				prod_q <= mul_p;
				sum_q  <= SUM_W'(prod_q);
			end
			svf_pkg::OP_SUM: begin
				sum_q <= sum_q + SUM_W'(prod_q);
			end
			svf_pkg::OP_CHECK: begin
				rad_q  <= RAD_W'(sum_q);
				root_q <= '0;
				rem_q  <= '0;
			end
			svf_pkg::OP_ROOT: begin
				rad_q  <= rad_q << 2;
				root_q <= {root_q[ROOT_W-2:0], root_fit};
				rem_q  <= root_fit ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			end
			svf_pkg::OP_VMUL: begin
				prod_q <= mul_p;
			end
			svf_pkg::OP_MULX: begin
				prod_q <= mul_p;
				drx_q  <= ROOT_W'(mx >> 1);
				dry_q  <= ROOT_W'(my >> 1);
				qx_q   <= '0;
				qy_q   <= '0;
			end
			svf_pkg::OP_MULY: begin
				prod_q <= mul_p;
				qx_q   <= MAG_W'(prod_q >> svf_pkg::GAIN_FRAC);
			end
			svf_pkg::OP_TAKEY: begin
				qy_q <= MAG_W'(prod_q >> svf_pkg::GAIN_FRAC);
			end
			svf_pkg::OP_DIV: begin
				qx_q  <= {qx_q[MAG_W-2:0], dgx};
				qy_q  <= {qy_q[MAG_W-2:0], dgy};
				drx_q <= dgx ? ROOT_W'(drx_sh - {1'b0, root_q}) : ROOT_W'(drx_sh);
				dry_q <= dgy ? ROOT_W'(dry_sh - {1'b0, root_q}) : ROOT_W'(dry_sh);
			end
			svf_pkg::OP_OUT: begin
				out_x_q  <= pos_x_q;
				out_y_q  <= pos_y_q;
				out_at_q <= (pos_x_q == tgt_x_q) && (pos_y_q == tgt_y_q);
			end
			default: ;
		endcase
	end

	assign pos_x     = out_x_q;
	assign pos_y     = out_y_q;
	assign at_target = out_at_q;

endmodule

FILE: hw/rtl/smoothed_viewport_follow_top.sv
`timescale 1ns / 1ps
// smoothed viewport follow, top level: sequencer plus datapath
// depends on svf_pkg, svf_ctrl, svf_datapath
//
// usage
//   input channel (in_valid/in_ready): one item per transfer, mode selects a
//   tick, a jump (position and target) or a go-to (target only); coordinates
//   are whole pixels, optionally centered by half the viewport size
//   output channel (out_valid/out_ready): exactly one result per input item,
//   position in fixed point with FRAC_BITS fraction bits and an at-target flag
//   config channel (cfg_valid/cfg_ready): always ready, index selects view
//   width, view height or follow gain; write only while the block is idle
//   jump, go-to and unused mode go straight to the result; a tick squares
//   and sums the offsets and snaps when within one pixel; a moving tick runs
//   the 33-step bit-serial square root, then, when the gain step is at least
//   one pixel, scales by the gain, else the one-bit-per-cycle step divider
//   one item is in work at a time; in_ready is high only while idle
//   the result sits in an output register, so a new item is taken while it
//   waits; a stalled receiver holds the next result back and blocks input
//   reset: position and target go to zero, registers to their defaults

module smoothed_viewport_follow_top #(
	parameter int FRAC_BITS = svf_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [svf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [svf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [svf_pkg::MODE_W-1:0]          mode,
	input  logic                                centered,
	input  logic signed [svf_pkg::PIX_W-1:0]    coord_x,
	input  logic signed [svf_pkg::PIX_W-1:0]    coord_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [svf_pkg::POS_W-1:0]    pos_x,
	output logic signed [svf_pkg::POS_W-1:0]    pos_y,
	output logic                                at_target
);

	svf_pkg::cmd_t    cmd;
	svf_pkg::status_t status;

	assign cfg_ready = 1'b1;

	svf_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	svf_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mode      (mode),
		.centered  (centered),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.cmd       (cmd),
		.status    (status),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.at_target (at_target)
	);

endmodule

FILE: hw/rtl/svf_checker.sv
`timescale 1ns / 1ps
// port-level checks of the smoothed viewport follow block, bound to the top
// depends on svf_pkg and smoothed_viewport_follow_top

module svf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [svf_pkg::MODE_W-1:0]          mode,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [svf_pkg::POS_W-1:0]    pos_x,
	input logic signed [svf_pkg::POS_W-1:0]    pos_y,
	input logic                                at_target
);

	// one item in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// input side closes only after a transfer
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("in_ready dropped without an input transfer");

	// a jump accepted while the output is free lands on its target and its result shows up
	a_jump_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == svf_pkg::MODE_JUMP && (!out_valid || out_ready)
		|-> ##2 (out_valid && at_target))
		else $error("jump result missing or not at target");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
		&& $stable(at_target))
		else $error("stalled result changed");

endmodule

bind smoothed_viewport_follow_top svf_checker u_svf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.mode      (mode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pos_x     (pos_x),
	.pos_y     (pos_y),
	.at_target (at_target)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for smoothed_viewport_follow_top: directed table, then random
// jump/go-to/tick/unused-mode sequences under several register settings, checked by the table or a local follow model
// depends on svf_pkg and smoothed_viewport_follow_top

module testbench;

	localparam int FRAC = svf_pkg::FRAC_BITS_DEF;
	localparam logic [63:0] PIX_ONE = 64'd1 << FRAC;
	localparam logic [svf_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [svf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [svf_pkg::POS_W-1:0] px;
		logic signed [svf_pkg::POS_W-1:0] py;
		logic                             hit;
	} view_t;

	typedef struct packed {
		logic [svf_pkg::MODE_W-1:0] m;
		logic                       ctr;
		logic [svf_pkg::PIX_W-1:0]  x;
		logic [svf_pkg::PIX_W-1:0]  y;
		logic                       known;
		view_t                      want;
	} probe_t;

	localparam probe_t DIRECTED [25] = '{
		'{svf_pkg::MODE_TICK, 1'b0, 24'd0,      24'd0,      1'b1, '{32'h0, 32'h0, 1'b1}},
		'{MODE_UNUSED,        1'b1, 24'h7FFFFF, 24'h800000, 1'b1, '{32'h0, 32'h0, 1'b1}},
		'{svf_pkg::MODE_JUMP, 1'b0, 24'h7FFFFF, 24'h800000, 1'b1,
			'{32'h7FFFFF00, 32'h80000000, 1'b1}},
		'{svf_pkg::MODE_GOTO, 1'b0, 24'h800000, 24'h7FFFFF, 1'b1,
			'{32'h7FFFFF00, 32'h80000000, 1'b0}},
		'{svf_pkg::MODE_TICK, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
		'{svf_pkg::MODE_TICK, 1'b1, 24'h000000, 24'h555555, 1'b0, '0},
		'{svf_pkg::MODE_JUMP, 1'b1, 24'd0,      24'd0,      1'b1,
			'{32'hFFFEC000, 32'hFFFF1000, 1'b1}},
		'{svf_pkg::MODE_JUMP, 1'b1, 24'h800000, 24'h800000, 1'b1,
			'{32'h7FFEC000, 32'h7FFF1000, 1'b1}},
		'{svf_pkg::MODE_JUMP, 1'b0, 24'd0,      24'd0,      1'b1, '{32'h0, 32'h0, 1'b1}},
		'{svf_pkg::MODE_GOTO, 1'b0, 24'd1,      24'd0,      1'b1, '{32'h0, 32'h0, 1'b0}},
		'{svf_pkg::MODE_TICK, 1'b0, 24'd0,      24'd0,      1'b1, '{32'h100, 32'h0, 1'b1}},
		'{svf_pkg::MODE_GOTO, 1'b0, 24'd1,      24'd1,      1'b1, '{32'h100, 32'h0, 1'b0}},
		'{svf_pkg::MODE_TICK, 1'b0, 24'd0,      24'd0,      1'b1,
			'{32'h100, 32'h100, 1'b1}},
		'{svf_pkg::MODE_GOTO, 1'b0, 24'd2,      24'd2,      1'b0, '0},
		'{svf_pkg::MODE_TICK, 1'b0, 24'd0,      24'd0,      1'b0, '0},
		'{svf_pkg::MODE_TICK, 1'b0, 24'd0,      24'd0,      1'b0, '0},
		'{svf_pkg::MODE_JUMP, 1'b0, 24'd0,      24'd0,      1'b1, '{32'h0, 32'h0, 1'b1}},
		'{svf_pkg::MODE_GOTO, 1'b0, 24'd100,    24'd0,      1'b1, '{32'h0, 32'h0, 1'b0}},
		'{svf_pkg::MODE_TICK, 1'b0, 24'd0,      24'd0,      1'b0, '0},
		'{svf_pkg::MODE_TICK, 1'b0, 24'd0,      24'd0,      1'b0, '0},
		'{svf_pkg::MODE_GOTO, 1'b1, 24'd320,    24'd340,    1'b0, '0},
		'{svf_pkg::MODE_TICK, 1'b0, 24'd0,      24'd0,      1'b0, '0},
		'{svf_pkg::MODE_GOTO, 1'b0, 24'd5,      24'hFFFFFB, 1'b0, '0},
		'{svf_pkg::MODE_TICK, 1'b0, 24'd0,      24'd0,      1'b0, '0},
		'{svf_pkg::MODE_TICK, 1'b0, 24'd0,      24'd0,      1'b0, '0}
	};

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [svf_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [svf_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;
	logic                              in_valid  = 1'b0;
	logic                              in_ready;
	logic [svf_pkg::MODE_W-1:0]        mode      = '0;
	logic                              centered  = 1'b0;
	logic signed [svf_pkg::PIX_W-1:0]  coord_x   = '0;
	logic signed [svf_pkg::PIX_W-1:0]  coord_y   = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [svf_pkg::POS_W-1:0]  pos_x;
	logic signed [svf_pkg::POS_W-1:0]  pos_y;
	logic                              at_target;

	// local copy of the follow state and registers
	logic signed [svf_pkg::POS_W-1:0]  cam_x, cam_y, aim_x, aim_y;
	logic [svf_pkg::SIZE_W-1:0]        view_w, view_h;
	logic [svf_pkg::GAIN_W-1:0]        view_gain;

	view_t pending[$];
	view_t want;
	int    errors     = 0;
	int    sent_items = 0;
	int    compared   = 0;
	int    settings   = 1;
	bit    idle_phase = 1'b1;
	bit    gap_on     = 1'b0;
	bit    stall_on   = 1'b0;

	smoothed_viewport_follow_top u_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [32:0] floor_root(logic [65:0] val);
		logic [67:0] rem, root, trial;
		rem = '0;
		root = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | 68'(val[2*i +: 2]);
			root = root << 1;
			trial = (root << 1) | 68'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = root | 68'd1;
			end
		end
		return root[32:0];
	endfunction

	// delta * num / den, truncated toward zero
	function automatic longint step_along(longint delta, logic [63:0] num, logic [63:0] den);
		logic [63:0] q;
		q = ((delta < 0) ? 64'(-delta) : 64'(delta)) * num / den;
		return (delta < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [svf_pkg::POS_W-1:0] pixel_to_fixed(
			logic [svf_pkg::PIX_W-1:0] pix, logic [svf_pkg::SIZE_W-1:0] size, logic ctr);
		longint p;
		p = {{40{pix[svf_pkg::PIX_W-1]}}, pix};
		if (ctr)
			p = p - longint'(size >> 1);
		return 32'(p << FRAC);
	endfunction

	function automatic void follow_tick();
		longint      dx, dy, stx, sty;
		logic [63:0] mx, my, d, v, g;
		logic [65:0] sq;
		dx = longint'(aim_x) - longint'(cam_x);
		dy = longint'(aim_y) - longint'(cam_y);
		mx = (dx < 0) ? 64'(-dx) : 64'(dx);
		my = (dy < 0) ? 64'(-dy) : 64'(dy);
		if (mx <= PIX_ONE && my <= PIX_ONE && mx * mx + my * my <= PIX_ONE * PIX_ONE) begin
			cam_x = aim_x;
			cam_y = aim_y;
		end else begin
			sq = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
			d = 64'(floor_root(sq));
			g = (view_gain > svf_pkg::GAIN_ONE) ? 64'(svf_pkg::GAIN_ONE) : 64'(view_gain);
			v = (d * g) >> svf_pkg::GAIN_FRAC;
			if (v >= PIX_ONE) begin
				stx = step_along(dx, g, 64'(svf_pkg::GAIN_ONE));
				sty = step_along(dy, g, 64'(svf_pkg::GAIN_ONE));
			end else begin
				stx = step_along(dx, PIX_ONE, d);
				sty = step_along(dy, PIX_ONE, d);
			end
			cam_x = cam_x + stx[31:0];
			cam_y = cam_y + sty[31:0];
		end
	endfunction

	function automatic view_t predict_item(logic [svf_pkg::MODE_W-1:0] m, logic c,
			logic [svf_pkg::PIX_W-1:0] x, logic [svf_pkg::PIX_W-1:0] y);
		view_t r;
		if (m == svf_pkg::MODE_TICK) begin
			follow_tick();
		end else if (m == svf_pkg::MODE_JUMP || m == svf_pkg::MODE_GOTO) begin
			aim_x = pixel_to_fixed(x, view_w, c);
			aim_y = pixel_to_fixed(y, view_h, c);
			if (m == svf_pkg::MODE_JUMP) begin
				cam_x = aim_x;
				cam_y = aim_y;
			end
		end
		r.px = cam_x;
		r.py = cam_y;
		r.hit = (cam_x == aim_x && cam_y == aim_y);
		return r;
	endfunction

	function automatic logic [svf_pkg::PIX_W-1:0] pick_coord();
		int v;
		case ($urandom_range(0, 3))
			0: v = int'($urandom_range(0, 80)) - 40;
			1: v = int'($urandom_range(0, 6000)) - 3000;
			2: v = int'($urandom_range(0, 400000)) - 200000;
			default: v = int'($urandom);
		endcase
		return v[svf_pkg::PIX_W-1:0];
	endfunction

	task automatic send_item(input logic [svf_pkg::MODE_W-1:0] m, input logic c,
			input logic [svf_pkg::PIX_W-1:0] x, input logic [svf_pkg::PIX_W-1:0] y,
			input logic known = 1'b0, input view_t given = '0);
		view_t pred;
		if (gap_on && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		centered <= c;
		coord_x  <= x;
		coord_y  <= y;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = predict_item(m, c, x, y);
		pending.push_back(known ? given : pred);
		sent_items++;
	endtask

	task automatic write_reg(input logic [svf_pkg::CFG_IDX_W-1:0] idx,
			input logic [svf_pkg::CFG_DATA_W-1:0] val);
		while (pending.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			svf_pkg::CFG_VIEW_WIDTH:  view_w = val[svf_pkg::SIZE_W-1:0];
			svf_pkg::CFG_VIEW_HEIGHT: view_h = val[svf_pkg::SIZE_W-1:0];
			svf_pkg::CFG_FOLLOW_GAIN: view_gain = val[svf_pkg::GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [svf_pkg::CFG_DATA_W-1:0] w,
			input logic [svf_pkg::CFG_DATA_W-1:0] h, input logic [svf_pkg::CFG_DATA_W-1:0] g);
		write_reg(svf_pkg::CFG_VIEW_WIDTH, w);
		write_reg(svf_pkg::CFG_VIEW_HEIGHT, h);
		write_reg(svf_pkg::CFG_FOLLOW_GAIN, g);
		write_reg(CFG_UNUSED, svf_pkg::CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic run_random(input int target);
		int                         done_items;
		int                         ticks;
		logic [svf_pkg::MODE_W-1:0] m;
		done_items = 0;
		while (done_items < target) begin
			gap_on = idle_phase && ($urandom_range(0, 3) != 0);
			stall_on = idle_phase && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				7: send_item(MODE_UNUSED, 1'($urandom), 24'($urandom), 24'($urandom));
				8: begin
					send_item(svf_pkg::MODE_TICK, 1'($urandom), 24'($urandom), 24'($urandom));
					done_items++;
				end
				9: begin
					m = 2'($urandom);
					send_item(m, 1'($urandom), 24'($urandom), 24'($urandom));
					if (m != MODE_UNUSED)
						done_items++;
				end
				default: begin
					// command followed by a run of ticks toward it
					m = ($urandom_range(0, 2) == 0) ? svf_pkg::MODE_JUMP : svf_pkg::MODE_GOTO;
					send_item(m, 1'($urandom), pick_coord(), pick_coord());
					ticks = $urandom_range(1, 12);
					repeat (ticks)
						send_item(svf_pkg::MODE_TICK, 1'($urandom), 24'($urandom),
							24'($urandom));
					done_items += 1 + ticks;
				end
			endcase
		end
	endtask

	// receiver stalls
	always begin
		@(posedge clk);
		if (stall_on && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %h %h %b",
					$time, pos_x, pos_y, at_target);
				errors++;
			end else begin
				want = pending.pop_front();
				compared++;
				if (pos_x !== want.px) begin
					$display("%0t ns: pos_x expected %h, actual %h", $time, want.px, pos_x);
					errors++;
				end
				if (pos_y !== want.py) begin
					$display("%0t ns: pos_y expected %h, actual %h", $time, want.py, pos_y);
					errors++;
				end
				if (at_target !== want.hit) begin
					$display("%0t ns: at_target expected %b, actual %b", $time, want.hit,
						at_target);
					errors++;
				end
			end
		end
	end

	initial begin
		cam_x = '0;
		cam_y = '0;
		aim_x = '0;
		aim_y = '0;
		view_w = svf_pkg::WIDTH_RST;
		view_h = svf_pkg::HEIGHT_RST;
		view_gain = svf_pkg::GAIN_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		gap_on = 1'b1;
		stall_on = 1'b1;
		foreach (DIRECTED[i])
			send_item(DIRECTED[i].m, DIRECTED[i].ctr, DIRECTED[i].x, DIRECTED[i].y,
				DIRECTED[i].known, DIRECTED[i].want);
		for (int ph = 0; ph < 5; ph++) begin
			in_valid <= 1'b0;
			case (ph)
				0: configure(17'd0, 17'd0, 17'd0);
				1: configure(17'd65535, 17'd65535, 17'd65536);
				2: configure(17'($urandom), 17'($urandom), 17'h1FFFF);
				3: configure(17'($urandom), 17'($urandom), 17'($urandom_range(0, 65536)));
				default: configure(17'(svf_pkg::WIDTH_RST), 17'(svf_pkg::HEIGHT_RST),
					17'(svf_pkg::GAIN_RST));
			endcase
			// final stretch runs without idling
			idle_phase = (ph != 4);
			run_random(85);
		end
		in_valid <= 1'b0;
		gap_on = 1'b0;
		stall_on = 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		$display("covered %0d input items over %0d register settings, %0d results compared",
			sent_items, settings, compared);
		$display("jumps, go-tos, snapping and moving ticks, unused mode, %0d mismatches", errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", pending.size());
		$display("FAIL");
		$finish;
	end

endmodule
